// File: rtl/core/minmax_byte_quantizer_top_macros.svh
// Assertion macros shared by the quantizer's checker.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef MINMAX_BYTE_QUANTIZER_TOP_MACROS_SVH
`define MINMAX_BYTE_QUANTIZER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBQ_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MBQ_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mbq_pkg.sv
// Package for the min/max byte quantizer: widths, codes and payload structs.
// Used by the top level and by the checker; depends on nothing.
`default_nettype none
package mbq_pkg;

  localparam int FRAC_BITS = 16;
  localparam int PF_W      = 20;
  localparam logic [PF_W-1:0] PF_RESET = 20'd10000;
  localparam int MX_W      = 44;
  localparam int PROD_W    = 66;
  localparam int DIV_W     = 64 - FRAC_BITS;
  localparam int DCNT_W    = $clog2(DIV_W);

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_SCAN   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;
  localparam logic [1:0] OP_QUANT  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_CLAMP = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] sample_value;
  } mbq_in_t;

  typedef struct packed {
    logic [7:0]         byte_out;
    logic signed [31:0] scale_out;
    logic signed [31:0] bias_out;
    logic [1:0]         status;
  } mbq_out_t;

endpackage
`default_nettype wire

// File: rtl/core/minmax_byte_quantizer_top.sv
// Start and scan items go straight to the output stage. A quantize item runs the multiplier
// and divider once (not when its sample is zero or the scale is not positive), a finish item
// twice (not when no nonzero data was seen). One item at a time: the next transfer is taken
// once the result enters the output register. The multiplier is 20-step, the divider 48-step.
// Reset (rst_n, synchronous, active low) clears the sequencer, the output valid,
// the tracked extremes, scale, bias and sets precision_factor to 10000.
`default_nettype none
module minmax_byte_quantizer_top (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  mbq_pkg::mbq_in_t        in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output mbq_pkg::mbq_out_t       out_data,
  input  logic                    cfg_wr_en,
  input  logic [mbq_pkg::PF_W-1:0] cfg_wr_data
);
  import mbq_pkg::*;

  // The sequencer walks one shared shift-add multiplier and one shared
  // restoring divider. A finish item runs both twice (scale, then bias).
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ADJ, S_DIV, S_FIN, S_OUT} state_t;
  typedef enum logic [1:0] {J_SCALE, J_BIAS, J_QUANT} job_t;

  state_t                    state_r;
  job_t                      job_r;
  logic [PF_W-1:0]           pf_r;
  logic signed [31:0]        run_min_r;
  logic signed [31:0]        run_max_r;
  logic signed [31:0]        scale_int_r;
  logic signed [31:0]        bias_int_r;
  logic                      nz_seen_r;
  logic signed [MX_W-1:0]    mx_r;
  logic signed [MX_W-1:0]    bias_x_r;
  logic signed [PROD_W-1:0]  acc_r;
  logic [4:0]                mcnt_r;
  logic [DCNT_W-1:0]         dcnt_r;
  logic                      neg_r;
  logic [DIV_W-1:0]          quo_r;
  logic [31:0]               rem_r;
  logic [31:0]               dvsr_r;
  logic [7:0]                res_byte_r;
  logic [1:0]                res_status_r;
  logic                      out_valid_r;
  mbq_out_t                  out_data_r;

  logic                      accept;
  logic signed [31:0]        v;
  logic signed [MX_W-1:0]    mn, mx, min10, max10, range10, bias_x, v_ext;
  logic signed [PROD_W-1:0]  addend, acc_nxt, sc_ext, bi_ext, qsum, t_fin, t_q;
  logic [DIV_W-1:0]          dvd, dvd_mag;
  logic [32:0]               trial, diff;
  logic                      ge;
  logic signed [DIV_W-1:0]   q;
  logic                      q_low, q_high;
  logic                      scale_bad;

  function automatic logic signed [31:0] sat32(input logic signed [DIV_W-1:0] x);
    logic pos_ovf;
    logic neg_ovf;
    pos_ovf = !x[DIV_W-1] && (|x[DIV_W-2:31]);
    neg_ovf = x[DIV_W-1] && !(&x[DIV_W-2:31]);
    if (pos_ovf) begin
      return 32'sh7fffffff;
    end else if (neg_ovf) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign v         = in_data.sample_value;

  // Extremes scaled by ten and widened by a tenth of their magnitude:
  // a nonnegative minimum gets 9x, a negative one 11x, and the reverse for max.
  assign mn    = {{(MX_W-32){run_min_r[31]}}, run_min_r};
  assign mx    = {{(MX_W-32){run_max_r[31]}}, run_max_r};
  assign min10 = run_min_r[31] ? (mn <<< 3) + (mn <<< 1) + mn : (mn <<< 3) + mn;
  assign max10 = run_max_r[31] ? (mx <<< 3) + mx : (mx <<< 3) + (mx <<< 1) + mx;
  assign range10 = max10 - min10;
  // Bias numerator before the factor: 254 * min10 - 2 * range10.
  assign bias_x  = (min10 <<< 8) - (min10 <<< 1) - (range10 <<< 1);
  assign v_ext   = {{(MX_W-32){v[31]}}, v};

  // Multiplier step, most significant factor bit first.
  assign addend  = pf_r[mcnt_r] ? {{(PROD_W-MX_W){mx_r[MX_W-1]}}, mx_r} : '0;
  assign acc_nxt = (acc_r <<< 1) + addend;

  // Dividend forming. Dividing by d * 2^FRAC_BITS equals flooring by
  // 2^FRAC_BITS first and then dividing by d. The finish rounding constant
  // 1270 * 2^FRAC_BITS therefore becomes +1270 after the shift.
  assign sc_ext = {{(PROD_W-32){scale_int_r[31]}}, scale_int_r};
  assign bi_ext = {{(PROD_W-32){bias_int_r[31]}}, bias_int_r};
  assign qsum   = acc_r + (sc_ext <<< (FRAC_BITS-1)) - (bi_ext <<< FRAC_BITS);
  assign t_q    = qsum >>> FRAC_BITS;
  assign t_fin  = (acc_r >>> FRAC_BITS) + PROD_W'(1270);
  assign dvd    = (job_r == J_QUANT) ? t_q[DIV_W-1:0] : t_fin[DIV_W-1:0];
  // Floor division of a negative n: floor(n/d) = ~floor(~n/d).
  assign dvd_mag = dvd[DIV_W-1] ? ~dvd : dvd;

  // Restoring divider step; the quotient shifts in where the dividend leaves.
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvsr_r};
  assign ge    = (trial >= {1'b0, dvsr_r});

  assign q      = neg_r ? $signed(~quo_r) : $signed(quo_r);
  assign q_low  = q[DIV_W-1] || (q == '0);
  assign q_high = !q[DIV_W-1] && (|q[DIV_W-2:8]);
  assign scale_bad = scale_int_r[31] || (scale_int_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      job_r       <= J_SCALE;
      pf_r        <= PF_RESET;
      run_min_r   <= 32'sh7fffffff;
      run_max_r   <= 32'sh80000000;
      scale_int_r <= '0;
      bias_int_r  <= '0;
      nz_seen_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pf_r <= cfg_wr_data;
      end
      // In S_OUT the output register is loaded below, which also settles its valid.
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            res_byte_r   <= '0;
            res_status_r <= ST_OK;
            acc_r        <= '0;
            mcnt_r       <= 5'(PF_W-1);
            state_r      <= S_OUT;
            unique case (in_data.opcode)
              OP_START: begin
                run_min_r <= 32'sh7fffffff;
                run_max_r <= 32'sh80000000;
                nz_seen_r <= 1'b0;
              end
              OP_SCAN: begin
                if (v > run_max_r) begin
                  run_max_r <= v;
                end
                if (v != '0) begin
                  nz_seen_r <= 1'b1;
                  if (v < run_min_r) begin
                    run_min_r <= v;
                  end
                end
              end
              OP_FINISH: begin
                if (!nz_seen_r) begin
                  scale_int_r  <= '0;
                  bias_int_r   <= '0;
                  res_status_r <= ST_EMPTY;
                end else begin
                  mx_r     <= range10;
                  bias_x_r <= bias_x;
                  job_r    <= J_SCALE;
                  state_r  <= S_MUL;
                end
              end
              OP_QUANT: begin
                if (v != '0) begin
                  if (scale_bad) begin
                    res_status_r <= ST_EMPTY;
                  end else begin
                    mx_r    <= v_ext;
                    job_r   <= J_QUANT;
                    state_r <= S_MUL;
                  end
                end
              end
              default: begin
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_MUL: begin
          acc_r <= acc_nxt;
          if (mcnt_r == '0) begin
            state_r <= S_ADJ;
          end else begin
            mcnt_r <= mcnt_r - 5'd1;
          end
        end
        S_ADJ: begin
          neg_r   <= dvd[DIV_W-1];
          quo_r   <= dvd_mag;
          rem_r   <= '0;
          dvsr_r  <= (job_r == J_QUANT) ? scale_int_r : 32'd2540;
          dcnt_r  <= DCNT_W'(DIV_W-1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= ge ? diff[31:0] : trial[31:0];
          quo_r <= {quo_r[DIV_W-2:0], ge};
          if (dcnt_r == '0) begin
            state_r <= S_FIN;
          end else begin
            dcnt_r <= dcnt_r - DCNT_W'(1);
          end
        end
        S_FIN: begin
          unique case (job_r)
            J_SCALE: begin
              scale_int_r <= sat32(q);
              mx_r        <= bias_x_r;
              acc_r       <= '0;
              mcnt_r      <= 5'(PF_W-1);
              job_r       <= J_BIAS;
              state_r     <= S_MUL;
            end
            J_BIAS: begin
              bias_int_r   <= sat32(q);
              res_status_r <= (scale_int_r == '0) ? ST_EMPTY : ST_OK;
              state_r      <= S_OUT;
            end
            default: begin
              if (q_low) begin
                res_byte_r   <= 8'd1;
                res_status_r <= ST_CLAMP;
              end else if (q_high) begin
                res_byte_r   <= 8'd255;
                res_status_r <= ST_CLAMP;
              end else begin
                res_byte_r <= q[7:0];
              end
              state_r <= S_OUT;
            end
          endcase
        end
        S_OUT: begin
          // The output register takes the result once its previous transfer is done.
          if (!out_valid_r || !out_stall) begin
            out_data_r.byte_out  <= res_byte_r;
            out_data_r.scale_out <= scale_int_r;
            out_data_r.bias_out  <= bias_int_r;
            out_data_r.status    <= res_status_r;
            out_valid_r          <= 1'b1;
            state_r              <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/mbq_checker.sv
// Port-level checker for the quantizer top level, bound to it below.
// Depends on mbq_pkg and minmax_byte_quantizer_top_macros.svh.
`default_nettype none
`include "minmax_byte_quantizer_top_macros.svh"
module mbq_checker (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_valid,
  input wire logic                     in_stall,
  input wire mbq_pkg::mbq_in_t         in_data,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire mbq_pkg::mbq_out_t        out_data,
  input wire logic                     cfg_wr_en,
  input wire logic [mbq_pkg::PF_W-1:0] cfg_wr_data
);
  import mbq_pkg::*;

  logic in_xfer;
  logic unused_ok;

  assign in_xfer   = in_valid && !in_stall;
  assign unused_ok = cfg_wr_en ^ (|cfg_wr_data) ^ (|in_data);

  `MBQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `MBQ_ASSERT_NEXT(a_busy_after_xfer, in_xfer, in_stall, "input taken while an item is in work")
  `MBQ_ASSERT_NOW(a_clamp_ends, out_valid && out_data.status == ST_CLAMP, out_data.byte_out == 8'd1 || out_data.byte_out == 8'd255, "clamped byte not at an end")
  `MBQ_ASSERT_NOW(a_empty_zero, out_valid && out_data.status == ST_EMPTY, out_data.byte_out == 8'd0, "byte nonzero with empty status")
  `MBQ_ASSERT_NOW(a_byte_scale, out_valid && out_data.byte_out != 8'd0, out_data.scale_out > 32'sd0, "byte given without positive scale")

endmodule

bind minmax_byte_quantizer_top mbq_checker u_mbq_checker (.*);
`default_nettype wire

// File: bench/mbq_checker.sv
// Checker for the min/max byte quantizer: watches both channels, predicts each result
// and compares it field by field. Depends on mbq_pkg.
`timescale 1ns / 1ps
module mbq_scoreboard (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  mbq_pkg::mbq_in_t         in_data,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  mbq_pkg::mbq_out_t        out_data,
  input  logic                     cfg_wr_en,
  input  logic [mbq_pkg::PF_W-1:0] cfg_wr_data,
  output int                       fail_count,
  output int                       pending_count
);
  import mbq_pkg::*;

  logic [PF_W-1:0]    factor;
  logic signed [31:0] run_min, run_max, scale_q, bias_q;
  logic               any_nonzero;
  mbq_out_t           expected_q[$];

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0))) q--;
    return q;
  endfunction

  function automatic logic signed [31:0] sat(longint x);
    if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // Updates the tracked state and returns the result one transfer causes.
  function automatic mbq_out_t quantize_step(mbq_in_t item);
    mbq_out_t r;
    longint v, mn10, mx10, rng10, one, num, den, q, f;
    v = item.sample_value;
    f = factor;
    one = 64'sd1 << FRAC_BITS;
    r = '0;
    r.status = ST_OK;
    case (item.opcode)
      OP_START: begin
        run_min = 32'sh7FFFFFFF;
        run_max = 32'sh80000000;
        any_nonzero = 1'b0;
      end
      OP_SCAN: begin
        if (v > run_max) run_max = v[31:0];
        if (v != 0) begin
          any_nonzero = 1'b1;
          if (v < run_min) run_min = v[31:0];
        end
      end
      OP_FINISH: begin
        if (!any_nonzero) begin
          scale_q = 0;
          bias_q = 0;
          r.status = ST_EMPTY;
        end else begin
          mn10 = (run_min >= 0) ? 9 * longint'(run_min) : 11 * longint'(run_min);
          mx10 = (run_max >= 0) ? 11 * longint'(run_max) : 9 * longint'(run_max);
          rng10 = mx10 - mn10;
          scale_q = sat(fdiv(rng10 * f + 1270 * one, 2540 * one));
          bias_q = sat(fdiv((254 * mn10 - 2 * rng10) * f + 1270 * one, 2540 * one));
          if (scale_q == 0) r.status = ST_EMPTY;
        end
      end
      default: begin
        if (v != 0) begin
          if (scale_q <= 0) begin
            r.status = ST_EMPTY;
          end else begin
            num = v * f - longint'(bias_q) * one;
            den = longint'(scale_q) * one;
            q = fdiv(num + den / 2, den);
            if (q < 1) begin
              q = 1;
              r.status = ST_CLAMP;
            end else if (q > 255) begin
              q = 255;
              r.status = ST_CLAMP;
            end
            r.byte_out = q[7:0];
          end
        end
      end
    endcase
    r.scale_out = scale_q;
    r.bias_out = bias_q;
    return r;
  endfunction

  assign pending_count = expected_q.size();

  always @(posedge clk) begin
    mbq_out_t e;
    int errs;
    errs = 0;
    if (!rst_n) begin
      factor <= PF_RESET;
      run_min = 32'sh7FFFFFFF;
      run_max = 32'sh80000000;
      scale_q = 0;
      bias_q = 0;
      any_nonzero = 1'b0;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_wr_en) factor <= cfg_wr_data;
      if (in_valid && !in_stall) expected_q.push_back(quantize_step(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected");
          errs++;
        end else begin
          e = expected_q.pop_front();
          if (e.byte_out !== out_data.byte_out) begin
            $error("byte_out: expected %0d actual %0d", e.byte_out, out_data.byte_out);
            errs++;
          end
          if (e.scale_out !== out_data.scale_out) begin
            $error("scale_out: expected %0d actual %0d", e.scale_out, out_data.scale_out);
            errs++;
          end
          if (e.bias_out !== out_data.bias_out) begin
            $error("bias_out: expected %0d actual %0d", e.bias_out, out_data.bias_out);
            errs++;
          end
          if (e.status !== out_data.status) begin
            $error("status: expected %0d actual %0d", e.status, out_data.status);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end
endmodule

// File: bench/tb_top.sv
// Testbench top for the min/max byte quantizer: drives stimulus and configuration,
// gives the verdict. Depends on mbq_pkg, mbq_scoreboard and the block itself.
`timescale 1ns / 1ps
module tb_top;
  import mbq_pkg::*;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  mbq_in_t         in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  mbq_out_t        out_data;
  logic            cfg_wr_en = 1'b0;
  logic [PF_W-1:0] cfg_wr_data = '0;
  int              fail_count, pending_count;
  int              send_idle_pct = 0, stall_pct = 0;
  int              idle_cycles = 0;

  localparam int WATCHDOG_LIMIT = 20000;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  minmax_byte_quantizer_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  mbq_scoreboard u_scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: counts cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL minmax_byte_quantizer_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one item, with a random idle gap first, and holds it until the transfer.
  // Valid stays up after the transfer until the next gap or item replaces it.
  task automatic send_item(input logic [1:0] op, input logic signed [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.opcode <= op;
    in_data.sample_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Waits for every expected result, then for the longest latency, so the block is idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_factor(input logic [PF_W-1:0] value);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Random sample: mostly moderate values, sometimes zero or extreme.
  function automatic logic signed [31:0] rand_sample();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 0;
    if (pick == 1) return $urandom();
    if (pick == 2) return ($urandom_range(1)) ? 32'sh7FFFFFFF : 32'sh80000000;
    return $signed($urandom_range(2000000)) - 1000000;
  endfunction

  // One well-formed field: start, scans, finish, then quantize items.
  task automatic run_field();
    int n;
    n = $urandom_range(6, 1);
    send_item(OP_START, $urandom());
    repeat (n) send_item(OP_SCAN, rand_sample());
    send_item(OP_FINISH, $urandom());
    n = $urandom_range(6, 1);
    repeat (n) send_item(OP_QUANT, rand_sample());
  endtask

  initial begin
    int sent;
    logic [PF_W-1:0] factors[6];
    factors = '{20'd10000, 20'd1, 20'd1000000, 20'd0, 20'hFFFFF, 20'd137};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: quantize before any finish, empty finish, extremes, clamps, zeros.
    send_item(OP_QUANT, 32'sd65536);
    send_item(OP_FINISH, 0);
    send_item(OP_START, 0);
    send_item(OP_SCAN, 0);
    send_item(OP_FINISH, 0);
    send_item(OP_START, 0);
    send_item(OP_SCAN, 32'sh80000000);
    send_item(OP_SCAN, 32'sh7FFFFFFF);
    send_item(OP_FINISH, 32'shFFFFFFFF);
    send_item(OP_QUANT, 32'sh80000000);
    send_item(OP_QUANT, 32'sh7FFFFFFF);
    send_item(OP_QUANT, 0);
    send_item(OP_QUANT, 32'sd1);
    send_item(OP_START, 0);
    send_item(OP_SCAN, -32'sd655360);
    send_item(OP_SCAN, 32'sd655360);
    send_item(OP_FINISH, 0);
    send_item(OP_QUANT, -32'sd6553600);
    send_item(OP_QUANT, 32'sd6553600);
    send_item(OP_QUANT, 32'sd1000);
    send_item(OP_START, 0);
    send_item(OP_SCAN, 32'sd3);
    send_item(OP_FINISH, 0);
    send_item(OP_QUANT, 32'sd3);

    // Random phases: each factor setting under each idling pattern.
    sent = 0;
    for (int ph = 0; ph < 24; ph++) begin
      if (ph % 4 == 0) write_factor(factors[ph / 4]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 57; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 57; end
        default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
      for (int k = 0; k < 4; k++) begin
        // Mostly well-formed fields; some loose random items as noise.
        if ($urandom_range(4) == 0) begin
          send_item(2'($urandom_range(3)), rand_sample());
        end else begin
          run_field();
        end
      end
      // After phase 5 the sender holds off until every outstanding result has arrived.
      if (ph == 5) drain();
    end

    send_idle_pct = 0;
    stall_pct = 0;
    drain();
    if (fail_count == 0) begin
      $display("PASS minmax_byte_quantizer_top");
    end else begin
      $display("FAIL minmax_byte_quantizer_top");
    end
    $finish;
  end
endmodule
